// File: sv/alarm_clock_menu_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Alarm clock menu controller: assertion macros
// Shared property wrappers; all sample on clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ALARM_CLOCK_MENU_CONTROLLER_UNIT_ASSERT_SVH
`define ALARM_CLOCK_MENU_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ACMC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACMC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/acmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_pkg
// Types and constants for the alarm clock menu controller.
// ----------------------------------------------------------------------------
package acmc_pkg;

  localparam int IDLE_W  = 21;
  localparam int RING_W  = 22;
  localparam int TMO_W   = 20;
  localparam int STEP_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int VOL_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [IDLE_W-1:0] IDLE_MAX   = {IDLE_W{1'b1}};
  localparam logic [RING_W-1:0] RING_MAX   = {RING_W{1'b1}};
  localparam logic [HOUR_W-1:0] HOUR_LAST  = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_LAST   = 6'd59;
  localparam logic [VOL_W-1:0]  VOL_MAX    = 7'd100;

  localparam logic [TMO_W-1:0]  TIMEOUT_RST  = 20'd10000;
  localparam logic [RING_W-1:0] DURATION_RST = 22'd30000;
  localparam logic [STEP_W-1:0] VSTEP_RST    = 5'd5;
  localparam logic [HOUR_W-1:0] HOUR_RST     = 5'd4;
  localparam logic [VOL_W-1:0]  VOL_RST      = 7'd50;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_STEP   = 2'd2;

  typedef enum logic [2:0] {
    EV_UP     = 3'd0,
    EV_DOWN   = 3'd1,
    EV_MID    = 3'd2,
    EV_LONG   = 3'd3,
    EV_TICK   = 3'd4,
    EV_SAMPLE = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_MENU   = 2'd1,
    MODE_ALARM  = 2'd2,
    MODE_VOLUME = 2'd3
  } mode_t;

  // Packed so that mode lands in the low bits, matching m_tdata.
  typedef struct packed {
    logic              save_request;
    logic              ringing;
    logic [VOL_W-1:0]  volume;
    logic [MIN_W-1:0]  alarm_minute;
    logic [HOUR_W-1:0] alarm_hour;
    logic              editing_minutes;
    logic              menu_choice;
    mode_t             mode;
  } result_t;

  // Configuration write request
  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// File: sv/acmc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acmc_core
// Controller state, configuration registers and combinational next-state logic.
// ----------------------------------------------------------------------------
`include "alarm_clock_menu_controller_unit_assert.svh"

module acmc_core (
  input  logic                           clk,
  input  logic                           rst,
  input  acmc_pkg::cfg_wr_t              cfg_wr,
  input  logic                           step,
  input  logic [2:0]                     func,
  input  logic [acmc_pkg::HOUR_W-1:0]    now_hour,
  input  logic [acmc_pkg::MIN_W-1:0]     now_minute,
  input  logic [acmc_pkg::SEC_W-1:0]     now_second,
  output acmc_pkg::result_t              res
);
  import acmc_pkg::*;

  // configuration
  logic [TMO_W-1:0]  idle_timeout;
  logic [RING_W-1:0] ring_duration;
  logic [STEP_W-1:0] volume_step;

  // state
  mode_t             mode_q,         mode_next;
  logic              menu_choice_q,  menu_choice_next;
  logic              field_q,        field_next;
  logic [HOUR_W-1:0] hour_q,         hour_next;
  logic [MIN_W-1:0]  minute_q,       minute_next;
  logic [VOL_W-1:0]  volume_q,       volume_next;
  logic [IDLE_W-1:0] idle_q,         idle_next;
  logic              ringing_q,      ringing_next;
  logic [RING_W-1:0] ring_q,         ring_next;
  logic              save_next;

  logic [IDLE_W-1:0] idle_inc;
  logic [RING_W-1:0] ring_inc;
  logic [VOL_W:0]    vol_sum;
  logic [VOL_W-1:0]  vol_up, vol_dn;
  logic [HOUR_W-1:0] hour_up, hour_dn;
  logic [MIN_W-1:0]  min_up, min_dn;
  logic              alarm_match;
  event_t            ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout  <= TIMEOUT_RST;
      ring_duration <= DURATION_RST;
      volume_step   <= VSTEP_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_IDLE_TIMEOUT:  idle_timeout  <= cfg_wr.data[TMO_W-1:0];
        CFG_RING_DURATION: ring_duration <= cfg_wr.data[RING_W-1:0];
        CFG_VOLUME_STEP:   volume_step   <= cfg_wr.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign ev       = event_t'(func);
  assign idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
  assign ring_inc = (ring_q == RING_MAX) ? ring_q : ring_q + 1'b1;
  assign vol_sum  = {1'b0, volume_q} + {{(VOL_W + 1 - STEP_W){1'b0}}, volume_step};
  assign vol_up   = (vol_sum > {1'b0, VOL_MAX}) ? VOL_MAX : vol_sum[VOL_W-1:0];
  assign vol_dn   = (volume_q > {{(VOL_W - STEP_W){1'b0}}, volume_step})
                  ? volume_q - {{(VOL_W - STEP_W){1'b0}}, volume_step}
                  : '0;
  assign hour_up  = (hour_q == HOUR_LAST) ? '0 : hour_q + 1'b1;
  assign hour_dn  = (hour_q == '0) ? HOUR_LAST : hour_q - 1'b1;
  assign min_up   = (minute_q == MIN_LAST) ? '0 : minute_q + 1'b1;
  assign min_dn   = (minute_q == '0) ? MIN_LAST : minute_q - 1'b1;
  assign alarm_match = (now_hour == hour_q) && (now_minute == minute_q)
                    && (now_second == '0);

  always_comb begin
    mode_next        = mode_q;
    menu_choice_next = menu_choice_q;
    field_next       = field_q;
    hour_next        = hour_q;
    minute_next      = minute_q;
    volume_next      = volume_q;
    idle_next        = idle_q;
    ringing_next     = ringing_q;
    ring_next        = ring_q;
    save_next        = 1'b0;
    unique case (ev)
      EV_UP, EV_DOWN: begin
        idle_next = '0;
        unique case (mode_q)
          MODE_ALARM: begin
            if (field_q) minute_next = (ev == EV_UP) ? min_up : min_dn;
            else         hour_next   = (ev == EV_UP) ? hour_up : hour_dn;
          end
          MODE_MENU:   menu_choice_next = ~menu_choice_q;
          MODE_VOLUME: volume_next = (ev == EV_UP) ? vol_up : vol_dn;
          default: ;
        endcase
      end
      EV_MID: begin
        idle_next = '0;
        unique case (mode_q)
          MODE_NORMAL: begin
            mode_next        = MODE_MENU;
            menu_choice_next = 1'b0;
          end
          MODE_MENU:  mode_next  = menu_choice_q ? MODE_VOLUME : MODE_ALARM;
          MODE_ALARM: field_next = ~field_q;
          default:    mode_next  = MODE_MENU;
        endcase
      end
      EV_LONG: begin
        if (mode_q == MODE_ALARM) begin
          mode_next = MODE_MENU;
          save_next = 1'b1;
        end else if (mode_q == MODE_MENU) begin
          mode_next = MODE_NORMAL;
        end
      end
      EV_TICK: begin
        idle_next = idle_inc;
        if (idle_inc > {1'b0, idle_timeout}) mode_next = MODE_NORMAL;
        ring_next = ring_inc;
        if (ringing_q && ring_inc >= ring_duration) ringing_next = 1'b0;
      end
      EV_SAMPLE: begin
        if (alarm_match) begin
          ringing_next = 1'b1;
          ring_next    = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q        <= MODE_NORMAL;
      menu_choice_q <= 1'b0;
      field_q       <= 1'b0;
      hour_q        <= HOUR_RST;
      minute_q      <= '0;
      volume_q      <= VOL_RST;
      idle_q        <= '0;
      ringing_q     <= 1'b0;
      ring_q        <= '0;
    end else if (step) begin
      mode_q        <= mode_next;
      menu_choice_q <= menu_choice_next;
      field_q       <= field_next;
      hour_q        <= hour_next;
      minute_q      <= minute_next;
      volume_q      <= volume_next;
      idle_q        <= idle_next;
      ringing_q     <= ringing_next;
      ring_q        <= ring_next;
    end
  end

  always_comb begin
    res.mode            = mode_next;
    res.menu_choice     = menu_choice_next;
    res.editing_minutes = field_next;
    res.alarm_hour      = hour_next;
    res.alarm_minute    = minute_next;
    res.volume          = volume_next;
    res.ringing         = ringing_next;
    res.save_request    = save_next;
  end

  `ACMC_ASSERT_IMP(a_vol_range, 1'b1, volume_q <= VOL_MAX, "volume above 100")
  `ACMC_ASSERT_IMP(a_time_range, 1'b1, hour_q <= HOUR_LAST && minute_q <= MIN_LAST,
                   "alarm time out of range")
  `ACMC_ASSERT_NXT(a_enter_menu, step && ev == EV_MID && mode_q == MODE_NORMAL,
                   mode_q == MODE_MENU && !menu_choice_q, "mid click did not open menu")
  `ACMC_ASSERT_IMP(a_save_mode, step && res.save_request,
                   mode_q == MODE_ALARM && res.mode == MODE_MENU,
                   "save request outside alarm set")

endmodule

// File: sv/alarm_clock_menu_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_clock_menu_controller_unit
// Three-button alarm clock menu controller with stream in/out and config port.
// ----------------------------------------------------------------------------
// Usage: each input request is one event (up, down, mid click, long mid
// press, millisecond tick or time-of-day sample, selected by s_tuser) and
// yields exactly one result carrying the full controller status after that
// event. The block takes one request per clock while m_tready does not
// hold the output; a request waits in the input register and its result
// is loaded into the output register (m_tdata) when it steps, through the
// combinational state update between the two registers. While a result
// waits on m_tready the input register still takes one more request.
// Configuration (idle timeout, ring duration, volume step) is written via
// cfg_valid/cfg_index/cfg_data, always ready, and should only change while
// no request is in flight. Event codes 6 and 7 change nothing and report
// the current status.
// ----------------------------------------------------------------------------
module alarm_clock_menu_controller_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [acmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [acmc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // event stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [2:0]                         s_tuser,  // [2:0] func
  input  logic [acmc_pkg::IN_DATA_W-1:0]     s_tdata,  // [4:0] now_hour, [10:5] now_minute,
                                                       // [16:11] now_second, [23:17] zero
  // status stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [acmc_pkg::OUT_DATA_W-1:0]    m_tdata   // [1:0] mode, [2] menu_choice,
                                                       // [3] editing_minutes,
                                                       // [8:4] alarm_hour_out,
                                                       // [14:9] alarm_minute_out,
                                                       // [21:15] volume_out,
                                                       // [22] ringing_out, [23] save_request
);
  import acmc_pkg::*;

  // input register
  logic              in_valid;
  logic [2:0]        in_func;
  logic [HOUR_W-1:0] in_hour;
  logic [MIN_W-1:0]  in_minute;
  logic [SEC_W-1:0]  in_second;

  logic    step;      // request in the input register moves to the output
  result_t res;
  cfg_wr_t cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Advance whenever the output register is free or being drained.
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func   <= s_tuser;
      in_hour   <= s_tdata[HOUR_W-1:0];
      in_minute <= s_tdata[HOUR_W+MIN_W-1:HOUR_W];
      in_second <= s_tdata[HOUR_W+MIN_W+SEC_W-1:HOUR_W+MIN_W];
    end
  end

  acmc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .step       (step),
    .func       (in_func),
    .now_hour   (in_hour),
    .now_minute (in_minute),
    .now_second (in_second),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= res;
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for alarm_clock_menu_controller_unit
// Drives button, tick and time-sample requests with random pauses on both
// stream sides. A scoreboard predicts the full status word for every
// accepted request and checks the results in order. The register set is
// reprogrammed between phases, including zero and all-ones settings.
// ----------------------------------------------------------------------------
module testbench;
  import acmc_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam int SETTLE_TICKS = 6;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all

  // unassigned event codes; the block must ignore them
  localparam logic [2:0] EV_SPARE_A = 3'd6;
  localparam logic [2:0] EV_SPARE_B = 3'd7;

  // --------------------------------------------------------------------------
  // Scoreboard: its own copy of the controller state and registers.
  // note_event() advances that state and queues the expected status word,
  // check_status() pops the oldest one and compares field by field.
  // --------------------------------------------------------------------------
  class menu_status_scoreboard;
    logic [TMO_W-1:0]  idle_timeout;
    logic [RING_W-1:0] ring_duration;
    logic [STEP_W-1:0] vol_step;
    mode_t             mode;
    logic              choice;
    logic              minutes_field;
    logic [HOUR_W-1:0] al_hour;
    logic [MIN_W-1:0]  al_min;
    logic [VOL_W-1:0]  volume;
    logic [IDLE_W-1:0] idle_ms;
    logic              ringing;
    logic [RING_W-1:0] ring_ms;
    result_t           status_due[$];
    int                errors;
    int                seen;

    function new();
      idle_timeout  = TIMEOUT_RST;
      ring_duration = DURATION_RST;
      vol_step      = VSTEP_RST;
      mode          = MODE_NORMAL;
      choice        = 1'b0;
      minutes_field = 1'b0;
      al_hour       = HOUR_RST;
      al_min        = '0;
      volume        = VOL_RST;
      idle_ms       = '0;
      ringing       = 1'b0;
      ring_ms       = '0;
      errors        = 0;
      seen          = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IDLE_TIMEOUT:  idle_timeout  = data[TMO_W-1:0];
        CFG_RING_DURATION: ring_duration = data[RING_W-1:0];
        CFG_VOLUME_STEP:   vol_step      = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_event(logic [2:0] func, logic [HOUR_W-1:0] hh,
                             logic [MIN_W-1:0] mm, logic [SEC_W-1:0] ss);
      result_t r;
      logic    save;
      logic    up;
      int      sum;
      save = 1'b0;
      up   = (func == EV_UP);
      case (func)
        EV_UP, EV_DOWN: begin
          idle_ms = '0;
          case (mode)
            MODE_ALARM: begin
              if (minutes_field) begin
                if (up) al_min = (al_min == MIN_LAST) ? '0 : al_min + 1'b1;
                else    al_min = (al_min == '0) ? MIN_LAST : al_min - 1'b1;
              end else begin
                if (up) al_hour = (al_hour == HOUR_LAST) ? '0 : al_hour + 1'b1;
                else    al_hour = (al_hour == '0) ? HOUR_LAST : al_hour - 1'b1;
              end
            end
            MODE_MENU: choice = ~choice;
            MODE_VOLUME: begin
              if (up) begin
                sum = int'(volume) + int'(vol_step);
                if (sum > int'(VOL_MAX)) volume = VOL_MAX;
                else volume = VOL_W'(sum);
              end else begin
                if (volume > vol_step) volume = volume - vol_step;
                else volume = '0;
              end
            end
            default: ;  // normal mode: click only clears the idle count
          endcase
        end
        EV_MID: begin
          idle_ms = '0;
          case (mode)
            MODE_NORMAL: begin
              mode   = MODE_MENU;
              choice = 1'b0;
            end
            MODE_MENU:  mode = choice ? MODE_VOLUME : MODE_ALARM;
            MODE_ALARM: minutes_field = ~minutes_field;
            default:    mode = MODE_MENU;
          endcase
        end
        EV_LONG: begin
          // long press leaves the idle count alone
          if (mode == MODE_ALARM) begin
            mode = MODE_MENU;
            save = 1'b1;
          end else if (mode == MODE_MENU) begin
            mode = MODE_NORMAL;
          end
        end
        EV_TICK: begin
          if (idle_ms != IDLE_MAX) idle_ms = idle_ms + 1'b1;
          if (idle_ms > idle_timeout && mode != MODE_NORMAL) mode = MODE_NORMAL;
          if (ring_ms != RING_MAX) ring_ms = ring_ms + 1'b1;
          if (ringing && ring_ms >= ring_duration) ringing = 1'b0;
        end
        EV_SAMPLE: begin
          if (hh == al_hour && mm == al_min && ss == '0) begin
            ringing = 1'b1;
            ring_ms = '0;
          end
        end
        default: ;  // unassigned codes change nothing
      endcase
      r.mode            = mode;
      r.menu_choice     = choice;
      r.editing_minutes = minutes_field;
      r.alarm_hour      = al_hour;
      r.alarm_minute    = al_min;
      r.volume          = volume;
      r.ringing         = ringing;
      r.save_request    = save;
      status_due.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch on result %0d: %s", $realtime, seen, what);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task check_status(logic [OUT_DATA_W-1:0] word);
      result_t got;
      result_t want;
      got = result_t'(word);
      if (status_due.size() == 0) begin
        report_mismatch($sformatf("unexpected status word %h", word));
      end else begin
        want = status_due.pop_front();
        compare_field("mode",             32'(got.mode),            32'(want.mode));
        compare_field("menu_choice",      32'(got.menu_choice),     32'(want.menu_choice));
        compare_field("editing_minutes",  32'(got.editing_minutes),
                      32'(want.editing_minutes));
        compare_field("alarm_hour_out",   32'(got.alarm_hour),      32'(want.alarm_hour));
        compare_field("alarm_minute_out", 32'(got.alarm_minute),    32'(want.alarm_minute));
        compare_field("volume_out",       32'(got.volume),          32'(want.volume));
        compare_field("ringing_out",      32'(got.ringing),         32'(want.ringing));
        compare_field("save_request",     32'(got.save_request),    32'(want.save_request));
      end
      seen++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [2:0]              s_tuser = '0;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;

  menu_status_scoreboard sb = new();

  bit tx_idle_on = 1'b0;  // sender inserts pauses between requests
  bit rx_idle_on = 1'b0;  // receiver stalls m_tready
  int stall_left = 0;
  int quiet_cycles = 0;

  alarm_clock_menu_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly no pause, some short ones, a few long ones.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and the status check.
  // Values are read at the edge, before any update of that edge lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left == 0 && rx_idle_on) stall_left = pick_pause();
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_status(m_tdata);
  end

  // Watchdog: too long without any handshake means the block hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[alarm_clock_menu_controller_unit] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. The request is noted by the scoreboard at the edge that
  // takes it, so the next random request already sees the updated state.
  // valid stays high across back-to-back requests.
  // --------------------------------------------------------------------------
  task automatic send_event(logic [2:0] func, logic [HOUR_W-1:0] hh,
                            logic [MIN_W-1:0] mm, logic [SEC_W-1:0] ss);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {7'b0, ss, mm, hh};
    do @(posedge clk); while (!s_tready);
    sb.note_event(func, hh, mm, ss);
    gap = tx_idle_on ? pick_pause() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Request with random time fields over their full encodable range.
  task automatic send_any(logic [2:0] func);
    logic [HOUR_W-1:0] hh;
    logic [MIN_W-1:0]  mm;
    logic [SEC_W-1:0]  ss;
    hh = HOUR_W'($urandom_range(0, 31));
    mm = MIN_W'($urandom_range(0, 63));
    ss = SEC_W'($urandom_range(0, 63));
    send_event(func, hh, mm, ss);
  endtask

  // Stop sending and wait until every expected status word is back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called while idle.
  task automatic program_regs(logic [TMO_W-1:0] tmo, logic [RING_W-1:0] dur,
                              logic [STEP_W-1:0] vstep);
    logic [CFG_IDX_W-1:0]  idx  [3];
    logic [CFG_DATA_W-1:0] vals [3];
    idx[0] = CFG_IDLE_TIMEOUT;  vals[0] = CFG_DATA_W'(tmo);
    idx[1] = CFG_RING_DURATION; vals[1] = dur;
    idx[2] = CFG_VOLUME_STEP;   vals[2] = CFG_DATA_W'(vstep);
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // One random request, or a burst of ticks so the idle and ring timers
  // actually expire. Samples mostly hit the current alarm time.
  task automatic send_random(output int sent);
    int r;
    int n;
    sent = 1;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      send_any(EV_TICK);
    end else if (r < 27) begin
      n = $urandom_range(5, 60);
      repeat (n) send_any(EV_TICK);
      sent = n;
    end else if (r < 42) begin
      send_any(EV_UP);
    end else if (r < 54) begin
      send_any(EV_DOWN);
    end else if (r < 70) begin
      send_any(EV_MID);
    end else if (r < 78) begin
      send_any(EV_LONG);
    end else if (r < 94) begin
      n = $urandom_range(0, 99);
      if (n < 65)      send_event(EV_SAMPLE, sb.al_hour, sb.al_min, '0);
      else if (n < 80) send_event(EV_SAMPLE, sb.al_hour, sb.al_min,
                                  SEC_W'($urandom_range(1, 63)));
      else             send_any(EV_SAMPLE);
    end else if (r < 97) begin
      send_any(($urandom_range(0, 1) != 0) ? EV_SPARE_B : EV_SPARE_A);
    end else begin
      send_any(3'($urandom_range(0, 7)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int done;
    int sent;
    int next_shuffle;
    logic [TMO_W-1:0]  tmo;
    logic [RING_W-1:0] dur;
    logic [STEP_W-1:0] vstep;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through every mode with reset register values.
    // Clicks in normal mode only clear the idle count; long press there is a no-op.
    send_event(EV_UP, 5'h1f, 6'h3f, 6'h3f);
    send_event(EV_DOWN, '0, '0, '0);
    send_event(EV_LONG, 5'h1f, 6'h3f, 6'h3f);
    send_event(EV_SPARE_A, 5'h15, 6'h2a, 6'h15);
    send_event(EV_SPARE_B, 5'h0a, 6'h15, 6'h2a);
    // alarm at its reset time starts ringing; a nonzero second and
    // out-of-range fields never match
    send_event(EV_SAMPLE, sb.al_hour, sb.al_min, '0);
    send_event(EV_SAMPLE, sb.al_hour, sb.al_min, 6'd1);
    send_event(EV_SAMPLE, 5'h1f, 6'h3f, 6'h3f);
    send_event(EV_MID, '0, '0, '0);     // main menu, choice alarm
    send_event(EV_UP, '0, '0, '0);      // choice toggles to volume
    send_event(EV_DOWN, '0, '0, '0);    // and back
    send_event(EV_MID, '0, '0, '0);     // alarm set, editing hours
    send_event(EV_DOWN, '0, '0, '0);
    send_event(EV_MID, '0, '0, '0);     // switch to minutes
    send_event(EV_DOWN, '0, '0, '0);    // minute wraps 0 -> 59
    send_event(EV_UP, '0, '0, '0);      // and 59 -> 0
    send_event(EV_LONG, '0, '0, '0);    // save pulse, back to menu
    send_event(EV_UP, '0, '0, '0);      // choice volume
    send_event(EV_MID, '0, '0, '0);     // volume set
    send_event(EV_UP, '0, '0, '0);
    send_event(EV_LONG, '0, '0, '0);    // ignored in volume set
    send_event(EV_DOWN, '0, '0, '0);
    send_event(EV_MID, '0, '0, '0);     // back to menu
    send_event(EV_LONG, '0, '0, '0);    // menu -> normal
    send_event(EV_TICK, '0, '0, '0);
    send_event(EV_SAMPLE, sb.al_hour, sb.al_min, '0);  // retrigger while ringing
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin tmo = '0;  dur = '0;  vstep = '0;      end
        1: begin
          tmo   = TMO_W'(1);
          dur   = RING_W'(1);
          vstep = STEP_W'(1);
        end
        2: begin tmo = '1;  dur = '1;  vstep = '1;      end
        3: begin
          tmo   = TMO_W'($urandom_range(1, 40));
          dur   = RING_W'($urandom_range(1, 80));
          vstep = 5'd20;
        end
        default: begin
          tmo   = TMO_W'($urandom_range(0, 60));
          dur   = RING_W'($urandom_range(0, 120));
          vstep = STEP_W'($urandom_range(0, 31));
        end
      endcase
      drain_results();
      program_regs(tmo, dur, vstep);

      done = 0;
      next_shuffle = 0;
      while (done < PHASE_ITEMS) begin
        // alternate stretches with and without pauses on each side
        if (done >= next_shuffle) begin
          tx_idle_on   = ($urandom_range(0, 3) != 0);
          rx_idle_on   = ($urandom_range(0, 3) != 0);
          next_shuffle = done + 50;
        end
        if ($urandom_range(0, 99) == 0) drain_results();
        send_random(sent);
        done += sent;
      end
    end

    drain_results();
    if (sb.errors == 0 && sb.status_due.size() == 0) begin
      $display("[alarm_clock_menu_controller_unit] OK");
    end else begin
      $display("[alarm_clock_menu_controller_unit] ERROR");
    end
    $finish;
  end

endmodule
